FILE: rtl/adrm_pkg.sv
// Shared types, widths, register indexes and reset values for the ADC deadband range mapper.
// No dependencies; every rtl file imports this package.
package adrm_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int OUT_BITS     = 32;
  localparam int DY_BITS      = OUT_BITS + 1;
  localparam int PROD_BITS    = DY_BITS + SAMPLE_BITS;
  localparam int SUM_BITS     = PROD_BITS + 2;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [SAMPLE_BITS-1:0]     raw_t;
  typedef logic signed [OUT_BITS-1:0] q16_t;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_LIMIT       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_LIMIT      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR_OUTPUT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEILING_OUTPUT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND_OUTPUT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERT          = 3'd6;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  localparam raw_t LOW_LIMIT_RESET      = raw_t'(0);
  localparam raw_t HIGH_LIMIT_RESET     = raw_t'(4095);
  localparam raw_t DEADBAND_WIDTH_RESET = raw_t'(2);
  localparam q16_t FLOOR_RESET          = q16_t'(0);
  localparam q16_t CEILING_RESET        = q16_t'(65536);
  localparam q16_t DEADBAND_OUT_RESET   = q16_t'(0);

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

FILE: rtl/adrm_mul.sv
// Serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Depends on adrm_pkg.
module adrm_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [adrm_pkg::DY_BITS-1:0]      mcand_i,
  input  adrm_pkg::raw_t                    mplier_i,
  output adrm_pkg::unit_sts_t               sts_o,
  output logic [adrm_pkg::PROD_BITS-1:0]    prod_o
);
  import adrm_pkg::*;

  localparam int CNT_BITS = $clog2(SAMPLE_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SAMPLE_BITS - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DY_BITS-1:0]  mcand_q;
  logic [DY_BITS-1:0]  hi_q;
  raw_t                lo_q;
  logic [DY_BITS:0]    sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // shift the partial product right, adding the multiplicand on a one bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= sum[DY_BITS:1];
      lo_q <= {sum[0], lo_q[SAMPLE_BITS-1:1]};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = {hi_q, lo_q};

endmodule

FILE: rtl/adrm_div.sv
// Restoring serial divider: one quotient bit per cycle, unsigned magnitudes.
// Depends on adrm_pkg; the divisor must be nonzero.
module adrm_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [adrm_pkg::PROD_BITS-1:0]    dvd_i,
  input  adrm_pkg::raw_t                    dvs_i,
  output adrm_pkg::unit_sts_t               sts_o,
  output logic [adrm_pkg::PROD_BITS-1:0]    quot_o
);
  import adrm_pkg::*;

  localparam int CNT_BITS = $clog2(PROD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PROD_BITS - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [PROD_BITS-1:0] dq_q;
  raw_t                 rem_q;
  raw_t                 dvs_q;
  logic [SAMPLE_BITS:0] shifted;
  logic [SAMPLE_BITS:0] diff;
  logic                 ge;

  assign shifted = {rem_q, dq_q[PROD_BITS-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dvd_i;
      rem_q <= '0;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[PROD_BITS-2:0], ge};
      rem_q <= ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = dq_q;

endmodule

FILE: rtl/adc_deadband_range_mapper.sv
// ADC deadband range mapper: raw sample to clamped, optionally negated Q16.16 value.
// A sloped segment runs setup, multiply, divide, sum and clamp; inside the deadband or on a
// zero span, setup goes straight to clamp. One item at a time: a new transaction is taken
// only once the result is loaded into the output register, not while the output is held off.
// The sloped path runs through the serial multiplier and the serial divider.
// Reset (asynchronous, active low) restores register defaults and clears sample and deadband.
// Depends on adrm_pkg, adrm_mul and adrm_div.
module adc_deadband_range_mapper (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [adrm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [adrm_pkg::OUT_BITS-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  adrm_pkg::raw_t                       sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output adrm_pkg::q16_t                       value_o
);
  import adrm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_CLAMP = 3'd5;

  // configuration
  raw_t low_q, high_q, db_width_q;
  q16_t floor_q, ceil_q, db_out_q;
  logic invert_q;

  // mapper state
  raw_t last_q, db_low_q, db_high_q;
  logic db_on_q;

  logic [2:0] state_q, state_d;
  logic       out_valid_q;
  q16_t       out_q;

  logic                       neg_q;
  q16_t                       y0_q;
  raw_t                       span_mag_q;
  logic signed [SUM_BITS-1:0] v_q;

  logic in_fire;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // deadband edges from the stored sample
  raw_t                 half, cap_low, cap_high;
  logic [SAMPLE_BITS:0] hi_sum;

  always_comb begin
    half     = (db_width_q == raw_t'(1)) ? raw_t'(1) : (db_width_q >> 1);
    hi_sum   = {1'b0, last_q} + {1'b0, half};
    cap_high = hi_sum[SAMPLE_BITS] ? '1 : hi_sum[SAMPLE_BITS-1:0];
    cap_low  = (last_q >= half) ? last_q - half : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q      <= LOW_LIMIT_RESET;
      high_q     <= HIGH_LIMIT_RESET;
      floor_q    <= FLOOR_RESET;
      ceil_q     <= CEILING_RESET;
      db_out_q   <= DEADBAND_OUT_RESET;
      db_width_q <= DEADBAND_WIDTH_RESET;
      invert_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_LIMIT:       low_q      <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_HIGH_LIMIT:      high_q     <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_FLOOR_OUTPUT:    floor_q    <= cfg_data_i;
        REG_CEILING_OUTPUT:  ceil_q     <= cfg_data_i;
        REG_DEADBAND_OUTPUT: db_out_q   <= cfg_data_i;
        REG_DEADBAND_WIDTH:  db_width_q <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_INVERT:          invert_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      db_low_q  <= '0;
      db_high_q <= '0;
      db_on_q   <= 1'b0;
    end else if (in_fire) begin
      if (opcode_i == OP_SAMPLE) begin
        last_q <= sample_i;
      end else begin
        db_low_q  <= cap_low;
        db_high_q <= cap_high;
        db_on_q   <= 1'b1;
      end
    end
  end

  // segment selection and operand preparation
  raw_t                       x0, x1;
  q16_t                       y0, y1;
  logic                       flat;
  logic signed [SAMPLE_BITS:0] dx, span;
  logic signed [DY_BITS-1:0]  dy;
  raw_t                       dx_mag, span_mag;
  logic [DY_BITS-1:0]         dy_mag;
  logic                       direct;

  always_comb begin
    x0   = low_q;
    y0   = floor_q;
    x1   = high_q;
    y1   = ceil_q;
    flat = 1'b0;
    if (db_on_q) begin
      if (last_q < db_low_q) begin
        x1 = db_low_q;
        y1 = db_out_q;
      end else if (last_q > db_high_q) begin
        x0 = db_high_q;
        y0 = db_out_q;
      end else begin
        y0   = db_out_q;
        flat = 1'b1;
      end
    end
    dx       = $signed({1'b0, last_q}) - $signed({1'b0, x0});
    span     = $signed({1'b0, x1}) - $signed({1'b0, x0});
    dy       = DY_BITS'(y1) - DY_BITS'(y0);
    dx_mag   = dx[SAMPLE_BITS] ? raw_t'(-dx) : dx[SAMPLE_BITS-1:0];
    span_mag = span[SAMPLE_BITS] ? raw_t'(-span) : span[SAMPLE_BITS-1:0];
    dy_mag   = dy[DY_BITS-1] ? DY_BITS'(-dy) : DY_BITS'(dy);
    direct   = flat || (span == '0);
  end

  unit_sts_t            mul_sts, div_sts;
  logic [PROD_BITS-1:0] prod, quot;
  logic                 mul_start, div_start;

  assign mul_start = (state_q == ST_SETUP) && !direct;
  assign div_start = (state_q == ST_MUL) && mul_sts.done;

  adrm_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (dy_mag),
    .mplier_i (dx_mag),
    .sts_o    (mul_sts),
    .prod_o   (prod)
  );

  adrm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (prod),
    .dvs_i   (span_mag_q),
    .sts_o   (div_sts),
    .quot_o  (quot)
  );

  // signed sum, clamp and optional negation
  logic signed [SUM_BITS-1:0] q_ext, q_signed, floor_ext, ceil_ext;
  q16_t                       clamped, result;
  logic                       slot_free;

  always_comb begin
    q_ext     = $signed({2'b00, quot});
    q_signed  = neg_q ? -q_ext : q_ext;
    floor_ext = SUM_BITS'(floor_q);
    ceil_ext  = SUM_BITS'(ceil_q);
    if (v_q < floor_ext) begin
      clamped = floor_q;
    end else if (v_q > ceil_ext) begin
      clamped = ceil_q;
    end else begin
      clamped = v_q[OUT_BITS-1:0];
    end
    if (!invert_q) begin
      result = clamped;
    end else if (clamped == {1'b1, {(OUT_BITS-1){1'b0}}}) begin
      result = {1'b0, {(OUT_BITS-1){1'b1}}};
    end else begin
      result = -clamped;
    end
    slot_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_SETUP;
      ST_SETUP: state_d = direct ? ST_CLAMP : ST_MUL;
      ST_MUL:   if (mul_sts.done) state_d = ST_DIV;
      ST_DIV:   if (div_sts.done) state_d = ST_SUM;
      ST_SUM:   state_d = ST_CLAMP;
      ST_CLAMP: if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLAMP && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP) begin
      y0_q       <= y0;
      neg_q      <= dx[SAMPLE_BITS] ^ span[SAMPLE_BITS] ^ dy[DY_BITS-1];
      span_mag_q <= span_mag;
      // deadband and zero span take the segment start as they are
      v_q        <= SUM_BITS'(y0);
    end
    if (state_q == ST_SUM) begin
      v_q <= SUM_BITS'(y0_q) + q_signed;
    end
    if (state_q == ST_CLAMP && slot_free) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input accepted while an item is still in progress");

  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_sts.done |-> (state_q == ST_MUL))
    else $error("multiplier finished outside the multiply phase");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy at once");

endmodule
